// ===== sv/line_sensor_calibrate_position_defines.svh =====
// ---------------------------------------------------------------------------
// Line sensor calibrate/position: assertion macros
// Concurrent check macros; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LINE_SENSOR_CALIBRATE_POSITION_DEFINES_SVH
`define LINE_SENSOR_CALIBRATE_POSITION_DEFINES_SVH
`ifndef SYNTHESIS
`define LSCP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lscp check failed");
`define LSCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lscp check failed");
`else
`define LSCP_ASSERT(label, clk, rst_n, ante, cons)
`define LSCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lscp_pkg.sv =====
// ---------------------------------------------------------------------------
// lscp_pkg
// Shared widths, codes and interface types of the line sensor position block.
// ---------------------------------------------------------------------------
`default_nettype none

package lscp_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_BITS  = 10;
    localparam int FRAC_BITS    = 8;
    localparam int SPACING_W    = 8;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 16;
    localparam int LEVEL_W      = 32;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);

    localparam int IN_DATA_W  = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = POS_W + SENSOR_COUNT * LEVEL_W;

    // channel sums and averages (Q.8)
    localparam int CHSUM_W   = SAMPLE_BITS + $clog2(SENSOR_COUNT);
    localparam int AVG_W     = SAMPLE_BITS + FRAC_BITS;
    // average = floor(256 * sum / SENSOR_COUNT) = (sum * AVG_RECIP) >> AVG_SHIFT
    localparam int AVG_SHIFT  = 16;
    localparam int RECIP_W    = 22;
    localparam int AVG_PROD_W = CHSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** (AVG_SHIFT + FRAC_BITS) + SENSOR_COUNT - 1) / SENSOR_COUNT);
    // level mapping
    localparam int SPAN_W = AVG_W + 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SPAN_W + DIFF_W - 1;
    // centroid
    localparam int SUM_W   = LEVEL_W + 3;
    localparam int NUM_W   = LEVEL_W + 3;
    localparam int SCALE_W = NUM_W + SPACING_W + 1;

    // shared divider
    localparam int DVD_W = SCALE_W - 1 + FRAC_BITS;
    localparam int DIV_W = SUM_W - 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    localparam logic [CNT_W-1:0] LVL_ITERS = CNT_W'(PROD_W - 1);
    localparam logic [CNT_W-1:0] POS_ITERS = CNT_W'(DVD_W);

    localparam logic [SPACING_W-1:0]  SPACING_RESET = SPACING_W'(12);
    localparam logic signed [SUM_W-1:0] SUM_FLOOR_Q8 = SUM_W'(3);
    localparam int POS_MAX_MAG = 2 ** (POS_W - 1) - 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_TRACK   = 2'd1,
        MODE_FINISH  = 2'd2,
        MODE_MEASURE = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNCAL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOW_SUM = 2'd2;

    typedef logic [SAMPLE_BITS-1:0]   sample_t;
    typedef sample_t [SENSOR_COUNT-1:0] sample_vec_t;
    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic clear;
        logic track;
        logic finish;
    } cal_cmd_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/lscp_divider.sv =====
// ---------------------------------------------------------------------------
// lscp_divider
// Shared restoring divider, one quotient bit per cycle. The dividend is
// left-aligned by the caller; iters sets how many top bits are consumed.
// ---------------------------------------------------------------------------
`default_nettype none

module lscp_divider
    import lscp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = rem_sh >= {1'b0, dvs_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/lscp_calib.sv =====
// ---------------------------------------------------------------------------
// lscp_calib
// Per-sensor minimum/maximum store and calibrated flag.
// ---------------------------------------------------------------------------
`default_nettype none

module lscp_calib
    import lscp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cal_cmd_t    cmd,
    input  wire sample_vec_t samples,
    output sample_vec_t      ch_min,
    output sample_vec_t      ch_max,
    output logic             calibrated
);

    sample_vec_t min_reg, min_next;
    sample_vec_t max_reg, max_next;
    logic        cal_reg, cal_next;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        cal_next = cal_reg;
        if (cmd.clear) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                min_next[i] = '1;
                max_next[i] = '0;
            end
            cal_next = 1'b0;
        end else if (cmd.track) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (samples[i] < min_reg[i]) begin
                    min_next[i] = samples[i];
                end
                if (samples[i] > max_reg[i]) begin
                    max_next[i] = samples[i];
                end
            end
        end else if (cmd.finish) begin
            cal_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                min_reg[i] <= '1;
                max_reg[i] <= '0;
            end
            cal_reg <= 1'b0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
            cal_reg <= cal_next;
        end
    end

    assign ch_min     = min_reg;
    assign ch_max     = max_reg;
    assign calibrated = cal_reg;

endmodule

`default_nettype wire

// ===== sv/line_sensor_calibrate_position.sv =====
// ---------------------------------------------------------------------------
// line_sensor_calibrate_position
// Min/max calibrated five-sensor line position estimator (top level).
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per frame; s_tuser is the mode (clear, track,
//   end tracking, measure), s_tdata the five raw samples.
//   Clear, track and end requests update the calibration and
//   give no result. A measure request gives one result on the m_ channel:
//   m_tuser is the status, m_tdata the Q7.8 position and Q23.8 levels.
//   cfg_ channel writes the sensor spacing; it is always ready.
//   A calibrated measure runs two reciprocal averages, then per sensor a
//   multiply and a 28-step division on the shared divider (skipped without
//   span), then numerator, scale and start of the 51-step position division,
//   and last loads the output register. A level sum below the floor ends
//   after the numerator; an uncalibrated measure goes straight to the output.
//   s_tready is low while a measure is in progress.
//   The result sits in an output register; while the receiver stalls, clear,
//   track and end requests are still taken, and a new measure waits to
//   deliver until the register frees.
//   Reset: minima all ones, maxima zero, not calibrated, spacing 12.
// ---------------------------------------------------------------------------
`default_nettype none
`include "line_sensor_calibrate_position_defines.svh"

module line_sensor_calibrate_position
    import lscp_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_DATA_W-1:0]    s_tdata,   // sample_0 .. sample_4, zero pad
    input  wire logic [MODE_W-1:0]       s_tuser,   // mode
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata,   // position, level_0 .. level_4
    output logic [STATUS_W-1:0]          m_tuser,   // status
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [SPACING_W-1:0]    cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_AVG_MIN   = 11'b00000000010,
        ST_AVG_MAX   = 11'b00000000100,
        ST_MUL       = 11'b00000001000,
        ST_LVL       = 11'b00000010000,
        ST_LVL_W     = 11'b00000100000,
        ST_NUM       = 11'b00001000000,
        ST_SCALE     = 11'b00010000000,
        ST_POS       = 11'b00100000000,
        ST_POS_W     = 11'b01000000000,
        ST_DONE      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]          idx_reg, idx_next;
    sample_vec_t               x_reg, x_next;
    logic [AVG_W-1:0]          amin_reg, amin_next;
    logic [AVG_W-1:0]          amax_reg, amax_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]    range_reg, range_next;
    logic                      span_reg, span_next;
    level_t                    level_reg [SENSOR_COUNT];
    level_t                    level_next [SENSOR_COUNT];
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [SCALE_W-1:0] scale_reg, scale_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [SPACING_W-1:0]      spacing_reg, spacing_next;

    logic                      m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]     m_data_reg, m_data_next;
    logic [STATUS_W-1:0]       m_status_reg, m_status_next;

    cal_cmd_t    cal_cmd;
    sample_vec_t ch_min;
    sample_vec_t ch_max;
    logic        cal_done;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        out_load;

    sample_vec_t              x_in;
    logic [CHSUM_W-1:0]       sum_min;
    logic [CHSUM_W-1:0]       sum_max;
    logic [CHSUM_W-1:0]       avg_dvd;
    logic [AVG_PROD_W-1:0]    avg_prod;
    logic [AVG_W-1:0]         avg_q;
    logic signed [SPAN_W-1:0] span_s;
    logic signed [DIFF_W-1:0] diff_s;
    logic [PROD_W-2:0]        prod_mag;
    logic signed [LEVEL_W-1:0] q_ext;
    level_t                   level_calc;
    logic [SCALE_W-2:0]       scale_mag;
    logic [DVD_W-1:0]         pos_q;
    logic                     last_idx;

    lscp_calib u_calib (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cal_cmd),
        .samples    (x_in),
        .ch_min     (ch_min),
        .ch_max     (ch_max),
        .calibrated (cal_done)
    );

    lscp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign x_in      = s_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        sum_min = '0;
        sum_max = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sum_min = sum_min + CHSUM_W'(ch_min[i]);
            sum_max = sum_max + CHSUM_W'(ch_max[i]);
        end
    end

    // one reciprocal multiplier serves both averages
    always_comb begin
        avg_dvd  = (state_reg == ST_AVG_MIN) ? sum_min : sum_max;
        avg_prod = AVG_PROD_W'(avg_dvd) * AVG_PROD_W'(AVG_RECIP);
        avg_q    = avg_prod[AVG_SHIFT +: AVG_W];
    end

    always_comb begin
        span_s     = $signed({1'b0, amax_reg}) - $signed({1'b0, amin_reg});
        diff_s     = $signed({1'b0, x_reg[idx_reg]}) - $signed({1'b0, ch_min[idx_reg]});
        prod_mag   = prod_reg[PROD_W-1] ? (PROD_W-1)'(-prod_reg) : prod_reg[PROD_W-2:0];
        q_ext      = $signed(LEVEL_W'(div_rsp.quotient[PROD_W-2:0]));
        level_calc = $signed(LEVEL_W'(amin_reg)) + (prod_reg[PROD_W-1] ? -q_ext : q_ext);
        scale_mag  = scale_reg[SCALE_W-1] ? (SCALE_W-1)'(-scale_reg)
                                          : scale_reg[SCALE_W-2:0];
        pos_q      = div_rsp.quotient;
        last_idx   = (idx_reg == IDX_W'(SENSOR_COUNT - 1));
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        x_next       = x_reg;
        amin_next    = amin_reg;
        amax_next    = amax_reg;
        prod_next    = prod_reg;
        range_next   = range_reg;
        span_next    = span_reg;
        level_next   = level_reg;
        sum_next     = sum_reg;
        num_next     = num_reg;
        scale_next   = scale_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        spacing_next = cfg_valid ? cfg_data : spacing_reg;
        cal_cmd      = '0;
        out_load     = 1'b0;
        div_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (mode_t'(s_tuser))
                        MODE_CLEAR:  cal_cmd.clear  = 1'b1;
                        MODE_TRACK:  cal_cmd.track  = 1'b1;
                        MODE_FINISH: cal_cmd.finish = 1'b1;
                        MODE_MEASURE: begin
                            x_next   = x_in;
                            idx_next = '0;
                            sum_next = '0;
                            pos_next = '0;
                            for (int i = 0; i < SENSOR_COUNT; i++) begin
                                level_next[i] = '0;
                            end
                            if (cal_done) begin
                                status_next = STATUS_OK;
                                state_next  = ST_AVG_MIN;
                            end else begin
                                status_next = STATUS_UNCAL;
                                state_next  = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_AVG_MIN: begin
                amin_next  = avg_q;
                state_next = ST_AVG_MAX;
            end
            ST_AVG_MAX: begin
                amax_next  = avg_q;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_W'(span_s) * PROD_W'(diff_s);
                span_next  = ch_max[idx_reg] > ch_min[idx_reg];
                range_next = ch_max[idx_reg] - ch_min[idx_reg];
                state_next = ST_LVL;
            end
            ST_LVL: begin
                if (span_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {prod_mag, {(DVD_W-PROD_W+1){1'b0}}};
                    div_req.divisor  = DIV_W'(range_reg);
                    div_req.iters    = LVL_ITERS;
                    state_next       = ST_LVL_W;
                end else begin
                    level_next[idx_reg] = $signed(LEVEL_W'(amin_reg));
                    sum_next   = sum_reg + SUM_W'($signed(LEVEL_W'(amin_reg)));
                    idx_next   = last_idx ? '0 : idx_reg + IDX_W'(1);
                    state_next = last_idx ? ST_NUM : ST_MUL;
                end
            end
            ST_LVL_W: begin
                if (div_rsp.done) begin
                    level_next[idx_reg] = level_calc;
                    sum_next   = sum_reg + SUM_W'(level_calc);
                    idx_next   = last_idx ? '0 : idx_reg + IDX_W'(1);
                    state_next = last_idx ? ST_NUM : ST_MUL;
                end
            end
            ST_NUM: begin
                num_next = NUM_W'(2) * (NUM_W'(level_reg[4]) - NUM_W'(level_reg[0]))
                         + (NUM_W'(level_reg[3]) - NUM_W'(level_reg[1]));
                if (sum_reg < SUM_FLOOR_Q8) begin
                    status_next = STATUS_LOW_SUM;
                    state_next  = ST_DONE;
                end else begin
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scale_next = SCALE_W'(num_reg) * SCALE_W'($signed({1'b0, spacing_reg}));
                state_next = ST_POS;
            end
            ST_POS: begin
                div_req.start    = 1'b1;
                div_req.dividend = {scale_mag, {FRAC_BITS{1'b0}}};
                div_req.divisor  = sum_reg[DIV_W-1:0];
                div_req.iters    = POS_ITERS;
                state_next       = ST_POS_W;
            end
            ST_POS_W: begin
                if (div_rsp.done) begin
                    if (scale_reg[SCALE_W-1]) begin
                        if (pos_q > DVD_W'(POS_MAX_MAG + 1)) begin
                            pos_next = {1'b1, {(POS_W-1){1'b0}}};
                        end else begin
                            pos_next = -pos_q[POS_W-1:0];
                        end
                    end else begin
                        if (pos_q > DVD_W'(POS_MAX_MAG)) begin
                            pos_next = {1'b0, {(POS_W-1){1'b1}}};
                        end else begin
                            pos_next = pos_q[POS_W-1:0];
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = status_reg;
            m_data_next[POS_W-1:0] = pos_reg;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                m_data_next[POS_W + i*LEVEL_W +: LEVEL_W] = level_reg[i];
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            spacing_reg <= SPACING_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            spacing_reg <= spacing_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        amin_reg     <= amin_next;
        amax_reg     <= amax_next;
        prod_reg     <= prod_next;
        range_reg    <= range_next;
        span_reg     <= span_next;
        level_reg    <= level_next;
        sum_reg      <= sum_next;
        num_reg      <= num_next;
        scale_reg    <= scale_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `LSCP_ASSERT(a_idle_div_free, aclk, aresetn, s_tready, !div_rsp.busy)
    `LSCP_ASSERT_NXT(a_measure_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == MODE_MEASURE), !s_tready)
    `LSCP_ASSERT(a_err_pos_zero, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OK), m_tdata[POS_W-1:0] == '0)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: line sensor calibrate/position testbench
// Drives clear, track, end and measure requests with random idle gaps on
// both streams, predicts each measure result from a local copy of the
// calibration state and the spacing register, and checks the status,
// position and levels of every result in order.
// ---------------------------------------------------------------------------

module tb;
    import lscp_pkg::*;

    typedef struct packed {
        mode_t       mode;
        sample_vec_t samples;
    } frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0]                   status;
        logic [POS_W-1:0]                      position;
        logic [SENSOR_COUNT-1:0][LEVEL_W-1:0] levels;
    } reading_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // sample_0 .. sample_4, zero pad
    logic [MODE_W-1:0]     s_tuser   = '0;   // mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // position, level_0 .. level_4
    logic [STATUS_W-1:0]   m_tuser;          // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SPACING_W-1:0]  cfg_data  = '0;

    // calibration shadow
    sample_t              track_lo [SENSOR_COUNT];
    sample_t              track_hi [SENSOR_COUNT];
    logic                 is_calibrated;
    logic [SPACING_W-1:0] spacing_mm;

    frame_t   pending_frames [$];
    reading_t expected_readings [$];
    frame_t   offered;
    int       tx_gap;
    int       tx_steady;
    int       rx_hold;
    int       rx_steady;
    int       results_seen;
    logic     long_hold_done;
    int       mismatch_count;

    line_sensor_calibrate_position DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #300_000_000;
        $display("[line_sensor_calibrate_position] ERROR");
        $finish;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 4);
        else if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    function automatic sample_t random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return sample_t'($urandom_range(0, 1023));
    endfunction

    function automatic sample_vec_t channel_only(input int k, input sample_t v);
        sample_vec_t s;
        s = '0;
        s[k] = v;
        return s;
    endfunction

    // Updates the calibration shadow; a measure queues its expected reading.
    function automatic void apply_frame(input frame_t f);
        longint   sum_lo, sum_hi, avg_lo, avg_hi, total, num, pos, x, lo, hi;
        longint   lv [SENSOR_COUNT];
        reading_t r;
        case (f.mode)
            MODE_CLEAR: begin
                for (int k = 0; k < SENSOR_COUNT; k++) begin
                    track_lo[k] = '1;
                    track_hi[k] = '0;
                end
                is_calibrated = 1'b0;
            end
            MODE_TRACK: begin
                for (int k = 0; k < SENSOR_COUNT; k++) begin
                    if (f.samples[k] < track_lo[k])
                        track_lo[k] = f.samples[k];
                    if (f.samples[k] > track_hi[k])
                        track_hi[k] = f.samples[k];
                end
            end
            MODE_FINISH: begin
                is_calibrated = 1'b1;
            end
            default: begin
                r = '0;
                if (!is_calibrated) begin
                    r.status = STATUS_UNCAL;
                end else begin
                    sum_lo = 0;
                    sum_hi = 0;
                    for (int k = 0; k < SENSOR_COUNT; k++) begin
                        lo = track_lo[k];
                        hi = track_hi[k];
                        sum_lo += lo;
                        sum_hi += hi;
                    end
                    avg_lo = (sum_lo * 256) / SENSOR_COUNT;
                    avg_hi = (sum_hi * 256) / SENSOR_COUNT;
                    total = 0;
                    for (int k = 0; k < SENSOR_COUNT; k++) begin
                        lo = track_lo[k];
                        hi = track_hi[k];
                        x  = f.samples[k];
                        if (hi > lo)
                            lv[k] = avg_lo + ((avg_hi - avg_lo) * (x - lo)) / (hi - lo);
                        else
                            lv[k] = avg_lo;
                        total += lv[k];
                        r.levels[k] = LEVEL_W'(lv[k]);
                    end
                    if (total < SUM_FLOOR_Q8) begin
                        r.status = STATUS_LOW_SUM;
                    end else begin
                        num = 2 * (lv[4] - lv[0]) + (lv[3] - lv[1]);
                        pos = (longint'(spacing_mm) * num * 256) / total;
                        if (pos > POS_MAX_MAG)
                            pos = POS_MAX_MAG;
                        if (pos < -POS_MAX_MAG - 1)
                            pos = -POS_MAX_MAG - 1;
                        r.status   = STATUS_OK;
                        r.position = POS_W'(pos);
                    end
                end
                expected_readings.push_back(r);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("%0t: result %0d %s got %h expected %h",
                     $time, results_seen, field, got, want);
        mismatch_count++;
    endtask

    // sender
    always @(posedge aclk) begin : sender
        frame_t nxt;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            tx_gap    <= 0;
            tx_steady <= 0;
        end else begin
            if (s_tvalid && s_tready)
                apply_frame(offered);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    nxt = pending_frames.pop_front();
                    offered  <= nxt;
                    s_tdata  <= IN_DATA_W'(nxt.samples);
                    s_tuser  <= nxt.mode;
                    s_tvalid <= 1'b1;
                    if (tx_steady != 0) begin
                        tx_steady <= tx_steady - 1;
                        tx_gap    <= 0;
                    end else if ($urandom_range(0, 49) == 0) begin
                        tx_steady <= $urandom_range(20, 80);
                        tx_gap    <= 0;
                    end else begin
                        tx_gap <= ($urandom_range(0, 9) < 4) ? 0 : idle_length();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off once results are flowing
    always @(posedge aclk) begin : receiver
        int r;
        if (!aresetn) begin
            m_tready       <= 1'b0;
            rx_hold        <= 0;
            rx_steady      <= 0;
            long_hold_done <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 60) begin
            long_hold_done <= 1'b1;
            rx_hold        <= 4000;
            m_tready       <= 1'b0;
        end else if (rx_steady != 0) begin
            rx_steady <= rx_steady - 1;
            m_tready  <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
            end else if (r < 70) begin
                rx_steady <= $urandom_range(20, 200);
                m_tready  <= 1'b1;
            end else begin
                rx_hold  <= idle_length();
                m_tready <= 1'b0;
            end
        end
    end

    // result check
    always @(posedge aclk) begin : result_check
        reading_t want;
        if (!aresetn) begin
            results_seen <= 0;
        end else if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(m_tuser), '0);
            end else begin
                want = expected_readings.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[POS_W-1:0] !== want.position)
                    report_mismatch("position", 32'(m_tdata[POS_W-1:0]),
                                    32'(want.position));
                for (int k = 0; k < SENSOR_COUNT; k++) begin
                    if (m_tdata[POS_W + LEVEL_W*k +: LEVEL_W] !== want.levels[k])
                        report_mismatch($sformatf("level_%0d", k),
                                        m_tdata[POS_W + LEVEL_W*k +: LEVEL_W],
                                        want.levels[k]);
                end
            end
        end
    end

    task automatic queue_frame(input mode_t m, input sample_vec_t s);
        frame_t f;
        f.mode    = m;
        f.samples = s;
        pending_frames.push_back(f);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_frames.size() != 0 || s_tvalid || expected_readings.size() != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_spacing(input logic [SPACING_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        spacing_mm = v;
    endtask

    // clear (usually), tracking, end (usually), then measures near the learned spans
    task automatic queue_sequence(inout int count);
        sample_vec_t s;
        int          base [SENSOR_COUNT];
        int          spread [SENSOR_COUNT];
        int          tracks, measures, v, r;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            base[k] = $urandom_range(0, 1023);
            r = $urandom_range(0, 9);
            spread[k] = (r == 0) ? 0 : (r < 4) ? $urandom_range(1, 20)
                                               : $urandom_range(1, 1023);
        end
        if ($urandom_range(0, 9) < 7) begin
            for (int k = 0; k < SENSOR_COUNT; k++)
                s[k] = random_sample();
            queue_frame(MODE_CLEAR, s);
            count++;
        end
        if ($urandom_range(0, 4) == 0) begin
            queue_frame(MODE_TRACK, '0);
            count++;
        end
        tracks = $urandom_range(1, 6);
        repeat (tracks) begin
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                v = base[k] + $urandom_range(0, spread[k]);
                s[k] = sample_t'((v > 1023) ? 1023 : v);
            end
            queue_frame(MODE_TRACK, s);
            count++;
        end
        if ($urandom_range(0, 9) != 0) begin
            for (int k = 0; k < SENSOR_COUNT; k++)
                s[k] = random_sample();
            queue_frame(MODE_FINISH, s);
            count++;
        end
        measures = $urandom_range(1, 6);
        repeat (measures) begin
            if ($urandom_range(0, 9) == 0) begin
                s = '0;
            end else begin
                for (int k = 0; k < SENSOR_COUNT; k++) begin
                    r = $urandom_range(0, 19);
                    if (r < 10) begin
                        v = base[k] + $urandom_range(0, spread[k]);
                        s[k] = sample_t'((v > 1023) ? 1023 : v);
                    end else if (r < 17) begin
                        s[k] = random_sample();
                    end else begin
                        s[k] = sample_t'($urandom_range(0, 1));
                    end
                end
            end
            queue_frame(MODE_MEASURE, s);
            count++;
        end
    endtask

    initial begin : stimulus
        sample_vec_t          s;
        logic [SPACING_W-1:0] phase_spacing [6];
        int                   count;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            track_lo[k] = '1;
            track_hi[k] = '0;
        end
        is_calibrated  = 1'b0;
        spacing_mm     = SPACING_RESET;
        mismatch_count = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset spacing
        queue_frame(MODE_MEASURE, '1);
        queue_frame(MODE_TRACK, {SENSOR_COUNT{10'h155}});
        queue_frame(MODE_MEASURE, {SENSOR_COUNT{10'h2AA}});   // tracked, not ended
        queue_frame(MODE_FINISH, '0);
        queue_frame(MODE_MEASURE, {SENSOR_COUNT{10'h2AA}});   // single track, no span
        queue_frame(MODE_CLEAR, {SENSOR_COUNT{10'h2AA}});
        queue_frame(MODE_FINISH, '1);
        queue_frame(MODE_MEASURE, '0);                        // cleared then ended
        queue_frame(MODE_CLEAR, '0);
        queue_frame(MODE_MEASURE, '1);                        // uncalibrated again
        queue_frame(MODE_TRACK, '0);
        queue_frame(MODE_TRACK, '1);
        queue_frame(MODE_FINISH, {SENSOR_COUNT{10'h155}});
        queue_frame(MODE_MEASURE, '0);                        // level sum too small
        queue_frame(MODE_MEASURE, channel_only(4, '1));
        queue_frame(MODE_MEASURE, channel_only(0, '1));
        queue_frame(MODE_MEASURE, '1);
        queue_frame(MODE_MEASURE, {SENSOR_COUNT{10'h155}});
        wait_drained();

        // widest spacing: both saturation limits
        write_spacing(8'd255);
        queue_frame(MODE_MEASURE, channel_only(4, '1));
        queue_frame(MODE_MEASURE, channel_only(0, '1));
        queue_frame(MODE_MEASURE, channel_only(3, '1));
        queue_frame(MODE_MEASURE, channel_only(1, 10'h200));
        wait_drained();

        phase_spacing[0] = 8'd1;
        phase_spacing[1] = 8'd255;
        phase_spacing[2] = SPACING_W'($urandom_range(1, 255));
        phase_spacing[3] = SPACING_RESET;
        phase_spacing[4] = SPACING_W'($urandom_range(1, 255));
        phase_spacing[5] = SPACING_W'($urandom_range(1, 255));
        for (int p = 0; p < 6; p++) begin
            write_spacing(phase_spacing[p]);
            count = 0;
            while (count < 300) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int k = 0; k < SENSOR_COUNT; k++)
                        s[k] = random_sample();
                    queue_frame(mode_t'($urandom_range(0, 3)), s);
                    count++;
                end else begin
                    queue_sequence(count);
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[line_sensor_calibrate_position] OK");
        else
            $display("[line_sensor_calibrate_position] ERROR");
        $finish;
    end

endmodule
